// ===== rtl/mcmf_pkg.sv =====
// mcmf_pkg: shared types and constants for the multi-channel mailbox FIFO.
// Used by mcmf_ctrl, mcmf_dp and the top level; depends on nothing.
`timescale 1ns / 1ps

package mcmf_pkg;

  // fixed field widths
  localparam int CHAN_W = 8;
  localparam int CFG_W  = 5;
  localparam int STS_W  = 2;

  localparam logic [CFG_W-1:0] CHAN_COUNT_RST = 5'd16;

  typedef enum logic [STS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_MAIL = 2'd1,
    ST_NO_BOX  = 2'd2,
    ST_FULL    = 2'd3
  } reply_code_t;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_REPLY
  } fsm_state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_wr;     // clear one pointer entry
    logic load_item;  // capture the input word
    logic meta_rd;    // read pointers of the addressed mailbox
    logic mark_bad;   // channel out of range
    logic exec;       // do the push or pop
    logic load_res;   // move result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic item_ok;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/mcmf_ram.sv =====
// mcmf_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module mcmf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/mcmf_ctrl.sv =====
// mcmf_ctrl: sequencing state machine of the mailbox FIFO.
// Depends on mcmf_pkg; drives mcmf_dp through cmd_t, watches sts_t.
`timescale 1ns / 1ps

module mcmf_ctrl
  import mcmf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (sts.item_ok) begin
          cmd.meta_rd = 1'b1;
          state_nxt   = S_DECIDE;
        end else begin
          cmd.mark_bad = 1'b1;
          state_nxt    = S_REPLY;
        end
      end
      S_DECIDE: begin
        cmd.exec  = 1'b1;
        state_nxt = S_REPLY;
      end
      S_REPLY: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          cmd.load_res = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/mcmf_dp.sv =====
// mcmf_dp: datapath of the mailbox FIFO: item and result registers, pointer RAM,
// mail RAM and output register. Depends on mcmf_pkg and mcmf_ram.
`timescale 1ns / 1ps

module mcmf_dp
  import mcmf_pkg::*;
#(
  parameter int MAX_CHANNELS = 16,
  parameter int QUEUE_DEPTH  = 16,
  parameter int MAIL_WIDTH   = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  logic                  in_action,
  input  logic [CHAN_W-1:0]     in_channel,
  input  logic                  in_direction,
  input  logic [MAIL_WIDTH-1:0] in_mail,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STS_W-1:0]      out_status,
  output logic [MAIL_WIDTH-1:0] out_mail,
  output logic                  out_is_full,
  output logic                  out_empty_flag
);

  localparam int BOX_COUNT = 2 * MAX_CHANNELS;
  localparam int BOX_W     = $clog2(BOX_COUNT);
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int META_W    = 2 * PTR_W + CNT_W;
  localparam int MAIL_DEPTH = BOX_COUNT * QUEUE_DEPTH;
  localparam int MADDR_W   = $clog2(MAIL_DEPTH);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  // configuration
  logic [CFG_W-1:0] chan_cnt_r;

  // captured input word
  action_t               act_r;
  logic [CHAN_W-1:0]     chan_r;
  logic                  dir_r;
  logic [MAIL_WIDTH-1:0] mail_r;

  logic [BOX_W-1:0]   clr_addr_r;
  logic [MADDR_W-1:0] base_r;

  // result hold
  reply_code_t res_status_r;
  logic        res_full_r;
  logic        res_empty_r;
  logic        res_pop_r;

  // output register
  logic                  out_valid_r;
  logic [STS_W-1:0]      out_status_r;
  logic [MAIL_WIDTH-1:0] out_mail_r;
  logic                  out_full_r;
  logic                  out_empty_r;

  logic [BOX_W-1:0]   box;
  logic [META_W-1:0]  meta_rd_data, meta_wr_data;
  logic [BOX_W-1:0]   meta_wr_addr;
  logic               meta_we;
  logic [PTR_W-1:0]   rptr, wptr, rptr_inc, wptr_inc;
  logic [CNT_W-1:0]   cnt, cnt_new;
  logic               full, empty, push_go, pop_go;
  logic               mail_we, mail_re;
  logic [MADDR_W-1:0] mail_wr_addr, mail_rd_addr;
  logic [MAIL_WIDTH-1:0] mail_rd_data;

  // mailbox index = 2*channel + direction; only used when channel is in range
  assign box = BOX_W'({chan_r, dir_r});

  assign sts.item_ok = ({1'b0, chan_r} < (CHAN_W + 1)'(MAX_CHANNELS)) &&
                       (chan_r < {{(CHAN_W - CFG_W){1'b0}}, chan_cnt_r});
  assign sts.clr_last = (clr_addr_r == BOX_W'(BOX_COUNT - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  assign {rptr, wptr, cnt} = meta_rd_data;
  assign full     = (cnt == CNT_FULL);
  assign empty    = (cnt == '0);
  assign rptr_inc = (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
  assign wptr_inc = (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
  assign push_go  = cmd.exec && (act_r == ACT_PUSH) && !full;
  assign pop_go   = cmd.exec && (act_r == ACT_POP) && !empty;

  always_comb begin
    cnt_new = cnt;
    if (push_go) begin
      cnt_new = cnt + 1'b1;
    end else if (pop_go) begin
      cnt_new = cnt - 1'b1;
    end
  end

  // pointer RAM: cleared after reset, then updated on every successful op
  always_comb begin
    meta_we      = cmd.clr_wr || push_go || pop_go;
    meta_wr_addr = cmd.clr_wr ? clr_addr_r : box;
    if (cmd.clr_wr) begin
      meta_wr_data = '0;
    end else if (push_go) begin
      meta_wr_data = {rptr, wptr_inc, cnt_new};
    end else begin
      meta_wr_data = {rptr_inc, wptr, cnt_new};
    end
  end

  mcmf_ram #(
    .WIDTH (META_W),
    .DEPTH (BOX_COUNT)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_we),
    .wr_addr (meta_wr_addr),
    .wr_data (meta_wr_data),
    .rd_en   (cmd.meta_rd),
    .rd_addr (box),
    .rd_data (meta_rd_data)
  );

  assign mail_we      = push_go;
  assign mail_re      = pop_go;
  assign mail_wr_addr = base_r + MADDR_W'(wptr);
  assign mail_rd_addr = base_r + MADDR_W'(rptr);

  mcmf_ram #(
    .WIDTH (MAIL_WIDTH),
    .DEPTH (MAIL_DEPTH)
  ) u_mail_ram (
    .clk     (clk),
    .wr_en   (mail_we),
    .wr_addr (mail_wr_addr),
    .wr_data (mail_r),
    .rd_en   (mail_re),
    .rd_addr (mail_rd_addr),
    .rd_data (mail_rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r  <= CHAN_COUNT_RST;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        chan_cnt_r <= cfg_wr_data;
      end
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.load_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_r  <= action_t'(in_action);
      chan_r <= in_channel;
      dir_r  <= in_direction;
      mail_r <= in_mail;
    end
    if (cmd.meta_rd) begin
      base_r <= MADDR_W'(box) * MADDR_W'(QUEUE_DEPTH);
    end
    if (cmd.mark_bad) begin
      res_status_r <= ST_NO_BOX;
      res_full_r   <= 1'b0;
      res_empty_r  <= 1'b1;
      res_pop_r    <= 1'b0;
    end else if (cmd.exec) begin
      if (act_r == ACT_PUSH) begin
        res_status_r <= full ? ST_FULL : ST_OK;
      end else begin
        res_status_r <= empty ? ST_NO_MAIL : ST_OK;
      end
      res_full_r  <= (cnt_new == CNT_FULL);
      res_empty_r <= (cnt_new == '0);
      res_pop_r   <= pop_go;
    end
    if (cmd.load_res) begin
      out_status_r <= res_status_r;
      out_mail_r   <= res_pop_r ? mail_rd_data : '0;
      out_full_r   <= res_full_r;
      out_empty_r  <= res_empty_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_mail       = out_mail_r;
  assign out_is_full    = out_full_r;
  assign out_empty_flag = out_empty_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !cmd.load_res)
    else $error("result loaded over a word still waiting");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_res |=> out_valid_r)
    else $error("loaded result not presented");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> cnt <= CNT_FULL)
    else $error("fill count beyond queue depth");

  a_mail_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mail_we && mail_re))
    else $error("mail RAM read and written in one cycle");

  a_bad_reply: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_bad |=> (res_status_r == ST_NO_BOX) && res_empty_r && !res_full_r)
    else $error("out-of-range channel result wrong");

endmodule

// ===== rtl/multi_channel_mailbox_fifo.sv =====
// multi_channel_mailbox_fifo: top level, per-channel ring-buffer mailboxes.
// Depends on mcmf_pkg, mcmf_ctrl, mcmf_dp (which holds two mcmf_ram instances).
`timescale 1ns / 1ps

// Channel   Handshake             Word
// in        in_valid / in_ready   in_action, in_channel, in_direction, in_mail
// out       out_valid / out_ready out_status, out_mail, out_is_full, out_empty_flag
// cfg       cfg_wr_en             cfg_wr_data (channel count, no wait)
//
// A word on a valid channel passes four steps from accept to accept when the output
// side is free: accept, pointer RAM read, push/pop against the mail RAM, reply
// load; out_valid rises once the reply is loaded. The registered pointer RAM read
// comes ahead of the read-modify-write. An out-of-range channel skips the pointer
// read and the push/pop.
// After reset a clearing pass zeroes all 2*MAX_CHANNELS pointer RAM entries;
// in_ready stays low during it. Config writes are taken at any time.
// A stalled output holds the reply state; the next word is accepted as soon
// as the pending result has moved into the output register.

module multi_channel_mailbox_fifo
  import mcmf_pkg::*;
#(
  parameter int MAX_CHANNELS = 16,
  parameter int QUEUE_DEPTH  = 16,
  parameter int MAIL_WIDTH   = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  // request side
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [CHAN_W-1:0]     in_channel,
  input  logic                  in_direction,
  input  logic [MAIL_WIDTH-1:0] in_mail,
  // reply side
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STS_W-1:0]      out_status,
  output logic [MAIL_WIDTH-1:0] out_mail,
  output logic                  out_is_full,
  output logic                  out_empty_flag
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: clear pass, then accept / lookup / execute / reply
  mcmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and result formatting
  mcmf_dp #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .MAIL_WIDTH   (MAIL_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_action      (in_action),
    .in_channel     (in_channel),
    .in_direction   (in_direction),
    .in_mail        (in_mail),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_mail       (out_mail),
    .out_is_full    (out_is_full),
    .out_empty_flag (out_empty_flag)
  );

endmodule
